// ===== src/aapr_pkg.sv =====
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared constants, CORDIC angle table and helpers for the point rotator.
// ----------------------------------------------------------------------------
package aapr_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned AxisWidth     = 16;
  localparam int unsigned AngleWidth    = 16;
  localparam int unsigned CordicSteps   = 30;
  // CORDIC datapath width: Q2.30 values with headroom
  localparam int unsigned CwW           = 34;

  localparam logic signed [CwW-1:0] CordicGain  = 34'sd652032874;
  localparam logic signed [CwW-1:0] QuarterTurn = 34'sd1073741824;

  typedef logic signed [CwW-1:0] cw_t;

  // Arctangent of 2^-i in units where 2^32 is one turn
  function automatic cw_t atan_at(input logic [4:0] idx);
    cw_t r;
    r = '0;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/aapr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aapr_cordic_cell
// One CORDIC micro-rotation stage; carries the item's point and axis along.
// ----------------------------------------------------------------------------
module aapr_cordic_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aapr_pkg::cw_t        x_i,
  input  aapr_pkg::cw_t        y_i,
  input  aapr_pkg::cw_t        z_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output aapr_pkg::cw_t        x_o,
  output aapr_pkg::cw_t        y_o,
  output aapr_pkg::cw_t        z_o,
  output logic [SIDE_W-1:0]    side_o
);
  import aapr_pkg::*;

  cw_t x_d, y_d, z_d, xs, ys, atan_v;

  // micro-rotation toward zero residual angle
  always_comb begin
    xs     = x_i >>> STEP;
    ys     = y_i >>> STEP;
    atan_v = atan_at(5'(STEP));
    if (!z_i[CwW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_v;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== src/aapr_matrix.sv =====
// ----------------------------------------------------------------------------
// aapr_matrix
// Quaternion from cos/sin and axis, rotation matrix, matrix-vector product,
// rounding and saturation. Pipelined, one item per cycle while en_i is high.
// ----------------------------------------------------------------------------
module aapr_matrix #(
  parameter int unsigned COORD_WIDTH = aapr_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  aapr_pkg::cw_t                 cx_i,
  input  aapr_pkg::cw_t                 cy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] pz_i,
  input  logic signed [15:0]            ax_i,
  input  logic signed [15:0]            ay_i,
  input  logic signed [15:0]            az_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] rx_o,
  output logic signed [COORD_WIDTH-1:0] ry_o,
  output logic signed [COORD_WIDTH-1:0] rz_o
);
  import aapr_pkg::*;

  localparam int unsigned Stages = 5;
  localparam int unsigned AccW   = COORD_WIDTH + 35;

  typedef logic signed [COORD_WIDTH-1:0] crd_t;

  logic [Stages-1:0] v_q;
  crd_t p1_q [3], p2_q [3], p3_q [3], p4_q [3];

  // stage 1: cos/sin clamp and round, axis clamp
  logic signed [17:0] c_d, s_d;
  logic signed [17:0] c_q, s_q;
  logic signed [15:0] a_d [3];
  logic signed [15:0] a_q [3];
  logic signed [15:0] ain [3];

  function automatic logic signed [17:0] to_q15(input cw_t v);
    cw_t cl, r;
    if (v > QuarterTurn) cl = QuarterTurn;
    else if (v < -QuarterTurn) cl = -QuarterTurn;
    else cl = v;
    r = (cl + 34'sd16384) >>> 15;
    return 18'(r);
  endfunction

  always_comb begin
    ain[0] = ax_i;
    ain[1] = ay_i;
    ain[2] = az_i;
    c_d = to_q15(-cy_i);
    s_d = to_q15(cx_i);
    for (int i = 0; i < 3; i++) begin
      if (ain[i] > 16'sd16384) a_d[i] = 16'sd16384;
      else if (ain[i] < -16'sd16384) a_d[i] = -16'sd16384;
      else a_d[i] = ain[i];
    end
  end

  // stage 2: quaternion in Q.29
  logic signed [31:0] qw_q, qa_q [3];

  // stage 3: nine products (Q.58)
  logic signed [63:0] t_q [9];

  // stage 4: matrix entries in Q.30
  logic signed [32:0] m_d [9];
  logic signed [32:0] m_q [9];

  function automatic logic signed [32:0] q30(input logic signed [65:0] tw);
    logic signed [65:0] r;
    r = (tw + 66'sd134217728) >>> 28;
    return 33'(r);
  endfunction

  always_comb begin
    // t index: 0 t2,1 t3,2 t4,3 t5,4 t6,5 t7,6 t8,7 t9,8 t10
    m_d[0] = 33'sd1073741824 + q30(66'(t_q[6]) + 66'(t_q[8]) <<< 1);
    m_d[1] = q30((66'(t_q[4]) - 66'(t_q[2])) <<< 1);
    m_d[2] = q30((66'(t_q[1]) + 66'(t_q[5])) <<< 1);
    m_d[3] = q30((66'(t_q[2]) + 66'(t_q[4])) <<< 1);
    m_d[4] = 33'sd1073741824 + q30((66'(t_q[3]) + 66'(t_q[8])) <<< 1);
    m_d[5] = q30((66'(t_q[7]) - 66'(t_q[0])) <<< 1);
    m_d[6] = q30((66'(t_q[5]) - 66'(t_q[1])) <<< 1);
    m_d[7] = q30((66'(t_q[0]) + 66'(t_q[7])) <<< 1);
    m_d[8] = 33'sd1073741824 + q30((66'(t_q[3]) + 66'(t_q[6])) <<< 1);
  end

  // stage 5: nine products matrix x point
  logic signed [COORD_WIDTH+32:0] pr_q [9];

  // output sum, round, saturate
  logic signed [AccW-1:0] acc [3];
  crd_t res_d [3];

  localparam logic signed [AccW-1:0] MaxV = AccW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [AccW-1:0] MinV = -MaxV - AccW'(1);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = (AccW'(pr_q[3*r]) + AccW'(pr_q[3*r+1]) + AccW'(pr_q[3*r+2])
                + AccW'(64'sd536870912)) >>> 30;
      if (acc[r] > MaxV) res_d[r] = MaxV[COORD_WIDTH-1:0];
      else if (acc[r] < MinV) res_d[r] = MinV[COORD_WIDTH-1:0];
      else res_d[r] = acc[r][COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[Stages-2:0], valid_i};
      valid_o <= v_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      s_q <= s_d;
      a_q <= a_d;
      p1_q[0] <= px_i; p1_q[1] <= py_i; p1_q[2] <= pz_i;
      qw_q <= 32'(c_q) <<< 14;
      for (int i = 0; i < 3; i++) qa_q[i] <= 32'(a_q[i]) * 32'(s_q);
      p2_q <= p1_q;
      t_q[0] <= 64'(qw_q) * 64'(qa_q[0]);
      t_q[1] <= 64'(qw_q) * 64'(qa_q[1]);
      t_q[2] <= 64'(qw_q) * 64'(qa_q[2]);
      t_q[3] <= -(64'(qa_q[0]) * 64'(qa_q[0]));
      t_q[4] <= 64'(qa_q[0]) * 64'(qa_q[1]);
      t_q[5] <= 64'(qa_q[0]) * 64'(qa_q[2]);
      t_q[6] <= -(64'(qa_q[1]) * 64'(qa_q[1]));
      t_q[7] <= 64'(qa_q[1]) * 64'(qa_q[2]);
      t_q[8] <= -(64'(qa_q[2]) * 64'(qa_q[2]));
      p3_q <= p2_q;
      m_q  <= m_d;
      p4_q <= p3_q;
      for (int i = 0; i < 9; i++)
        pr_q[i] <= (COORD_WIDTH+33)'(m_q[i]) * (COORD_WIDTH+33)'(p4_q[i%3]);
      rx_o <= res_d[0];
      ry_o <= res_d[1];
      rz_o <= res_d[2];
    end
  end

endmodule

// ===== src/axis_angle_point_rotator.sv =====
// ----------------------------------------------------------------------------
// axis_angle_point_rotator
// Rotates a Q16.16 point about a Q1.14 unit axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries a point, an axis and a turn
//   angle (65536 = one turn). Output channel out_valid_o/out_ready_i carries
//   the rotated, rounded and saturated point. One result per item.
//   The half angle drives a chain of 30 CORDIC cells, one micro-rotation per
//   cell, followed by a 6-stage quaternion/matrix pipeline. Throughput is
//   one item per cycle while the receiver does not stall.
//   The whole pipeline advances together: it moves when the output register
//   is empty or being taken, so in_ready_o tracks that condition and the
//   block keeps accepting while a result is being handed off.
//   When the receiver stalls, the pipeline freezes and holds every item.
//   Reset clears all valid flags; no item is in flight after reset.
// ----------------------------------------------------------------------------
module axis_angle_point_rotator #(
  parameter int unsigned COORD_WIDTH = aapr_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [15:0]            axis_x_i,
  input  logic signed [15:0]            axis_y_i,
  input  logic signed [15:0]            axis_z_i,
  input  logic [15:0]                   turn_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic signed [COORD_WIDTH-1:0] rotated_z_o
);
  import aapr_pkg::*;

  localparam int unsigned SideW = 3 * COORD_WIDTH + 3 * AxisWidth;
  localparam int unsigned N     = CordicSteps;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic              cv [N+1];
  cw_t               cx [N+1];
  cw_t               cy [N+1];
  cw_t               cz [N+1];
  logic [SideW-1:0]  sd [N+1];

  // chain head: start vector and half-angle residual
  assign cv[0] = in_valid_i;
  assign cx[0] = CordicGain;
  assign cy[0] = '0;
  assign cz[0] = (cw_t'(turn_angle_i) <<< 15) - QuarterTurn;
  assign sd[0] = {point_x_i, point_y_i, point_z_i, axis_x_i, axis_y_i, axis_z_i};

  for (genvar g = 0; g < N; g++) begin : g_cell
    aapr_cordic_cell #(.STEP(g), .SIDE_W(SideW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[g]), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .side_i(sd[g]),
      .valid_o(cv[g+1]), .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]),
      .side_o(sd[g+1])
    );
  end

  aapr_matrix #(.COORD_WIDTH(COORD_WIDTH)) u_matrix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv[N]),
    .cx_i(cx[N]), .cy_i(cy[N]),
    .px_i(sd[N][SideW-1 -: COORD_WIDTH]),
    .py_i(sd[N][SideW-COORD_WIDTH-1 -: COORD_WIDTH]),
    .pz_i(sd[N][3*AxisWidth +: COORD_WIDTH]),
    .ax_i(sd[N][2*AxisWidth +: AxisWidth]),
    .ay_i(sd[N][AxisWidth +: AxisWidth]),
    .az_i(sd[N][0 +: AxisWidth]),
    .valid_o(out_valid_o),
    .rx_o(rotated_x_o), .ry_o(rotated_y_o), .rz_o(rotated_z_o)
  );

  // a stalled result must stay put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rotated_x_o))
    else $error("result changed under stall");
  // ready follows the output register state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("ready low with empty output");
  // the chain holds still while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(cv[N]))
    else $error("pipeline moved while stalled");

endmodule
